@@ rtl/core/sdr_pkg.sv @@
// ----------------------------------------------------------------------------
// sdr_pkg: shared widths and types for the segment direction rescale block
// Holds the fixed datapath widths and the sideband structs that travel
// alongside the square root and divider pipelines.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int unsigned CoordW = 32;  // input point coordinate
  localparam int unsigned AbsW   = 32;  // magnitude of one difference
  localparam int unsigned LenW   = 31;  // target length
  localparam int unsigned SqW    = 64;  // square of one difference
  localparam int unsigned SumW   = 66;  // sum of three squares
  localparam int unsigned RootW  = 33;  // integer square root of the sum
  localparam int unsigned RemW   = 35;  // square root partial remainder
  localparam int unsigned ProdW  = 63;  // difference times length
  localparam int unsigned NumW   = 64;  // rounded dividend
  localparam int unsigned QuoW   = 31;  // quotient bits
  localparam int unsigned DremW  = 33;  // divider partial remainder
  localparam int unsigned OutW   = 32;  // result component

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } sdr_flags_t;

  typedef struct packed {
    sdr_flags_t              flags;
    logic [LenW-1:0]         len;
    logic [2:0][AbsW-1:0]    ad;
  } sdr_side_t;

endpackage

@@ rtl/core/sdr_sqrt.sv @@
// ----------------------------------------------------------------------------
// sdr_sqrt: pipelined integer square root
// One result bit per stage, digit by digit, with the item's sideband
// carried alongside. All stages move together when en_i is high.
// ----------------------------------------------------------------------------
module sdr_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [sdr_pkg::SumW-1:0] sum_i,
  input  sdr_pkg::sdr_side_t       side_i,
  output logic                     valid_o,
  output logic [sdr_pkg::RootW-1:0] root_o,
  output sdr_pkg::sdr_side_t       side_o
);
  import sdr_pkg::*;

  logic             vld  [RootW+1];
  logic [SumW-1:0]  rad  [RootW+1];
  logic [RemW-1:0]  rem  [RootW+1];
  logic [RootW-1:0] root [RootW+1];
  sdr_side_t        side [RootW+1];

  assign vld[0]  = valid_i;
  assign rad[0]  = sum_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    logic            take;

    always_comb begin
      cur   = {rem[k], rad[k][SumW-1 -: 2]};
      trial = cur - {2'b00, root[k], 2'b01};
      take  = ~trial[RemW+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad[k+1]  <= {rad[k][SumW-3:0], 2'b00};
        rem[k+1]  <= take ? trial[RemW-1:0] : cur[RemW-1:0];
        root[k+1] <= {root[k][RootW-2:0], take};
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = vld[RootW];
  assign root_o  = root[RootW];
  assign side_o  = side[RootW];

endmodule

@@ rtl/core/sdr_div.sv @@
// ----------------------------------------------------------------------------
// sdr_div: three-lane pipelined restoring divider
// Divides three dividends by one shared divisor, one quotient bit per
// stage. The quotient is known to fit in QuoW bits.
// ----------------------------------------------------------------------------
module sdr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [2:0][sdr_pkg::NumW-1:0]    num_i,
  input  logic [sdr_pkg::RootW-1:0]        mag_i,
  input  sdr_pkg::sdr_flags_t              flags_i,
  output logic                             valid_o,
  output logic [2:0][sdr_pkg::QuoW-1:0]    quo_o,
  output sdr_pkg::sdr_flags_t              flags_o
);
  import sdr_pkg::*;

  logic                   vld   [QuoW+1];
  logic [2:0][DremW-1:0]  rem   [QuoW+1];
  logic [2:0][QuoW-1:0]   low   [QuoW+1];
  logic [RootW-1:0]       mag   [QuoW+1];
  sdr_flags_t             flags [QuoW+1];

  assign vld[0]   = valid_i;
  assign mag[0]   = mag_i;
  assign flags[0] = flags_i;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = num_i[l][NumW-1:QuoW];
    assign low[0][l] = num_i[l][QuoW-1:0];
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [2:0][DremW-1:0] rem_d;
    logic [2:0][QuoW-1:0]  low_d;

    always_comb begin
      logic [DremW:0]   cur;
      logic [DremW+1:0] diff;
      for (int l = 0; l < 3; l++) begin
        cur      = {rem[k][l], low[k][l][QuoW-1]};
        diff     = {1'b0, cur} - {2'b00, mag[k]};
        rem_d[l] = diff[DremW+1] ? cur[DremW-1:0] : diff[DremW-1:0];
        low_d[l] = {low[k][l][QuoW-2:0], ~diff[DremW+1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]   <= rem_d;
        low[k+1]   <= low_d;
        mag[k+1]   <= mag[k];
        flags[k+1] <= flags[k];
      end
    end
  end

  assign valid_o = vld[QuoW];
  assign quo_o   = low[QuoW];
  assign flags_o = flags[QuoW];

endmodule

@@ rtl/core/segment_direction_rescale.sv @@
// ----------------------------------------------------------------------------
// segment_direction_rescale: rescale a 3D segment to a target length
// Takes two points and a length, forms the difference vector, divides it
// by its Euclidean magnitude and multiplies by the length, rounding each
// component to nearest with halves away from zero.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i/in_ready_o, from_*,   | input
//           | to_*, target_length_i            |
//   out     | out_valid_o/out_ready_i, out_*,  | output
//           | zero_error_o                     |
//
// The pipeline takes one item per cycle unless the output item is held.
// From acceptance to the result showing at the output register, an item
// passes three front stages, 33 square root stages, two stages that form
// the rounded dividend, 31 divider stages and the output register. Reset
// clears only the valid bits. When the output item is held, every stage
// freezes together, so a stall loses and repeats nothing; the input is
// ready whenever the output register is empty or being taken.
module segment_direction_rescale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           from_x_i,
  input  logic signed [31:0]           from_y_i,
  input  logic signed [31:0]           from_z_i,
  input  logic signed [31:0]           to_x_i,
  input  logic signed [31:0]           to_y_i,
  input  logic signed [31:0]           to_z_i,
  input  logic [30:0]                  target_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           out_x_o,
  output logic signed [31:0]           out_y_o,
  output logic signed [31:0]           out_z_o,
  output logic                         zero_error_o
);
  import sdr_pkg::*;

  // Whole pipeline advances together.
  logic adv;
  logic out_valid_q;

  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  // Stage 0: differences at 33 bits, split into sign and magnitude.
  logic [2:0][CoordW-1:0] from_c;
  logic [2:0][CoordW-1:0] to_c;
  sdr_side_t              s0_d;
  sdr_side_t              s0_q;
  logic                   s0_v_q;

  assign from_c = {from_z_i, from_y_i, from_x_i};
  assign to_c   = {to_z_i, to_y_i, to_x_i};

  always_comb begin
    logic [CoordW:0] diff;
    s0_d            = '0;
    s0_d.len        = target_length_i;
    for (int i = 0; i < 3; i++) begin
      diff               = {to_c[i][CoordW-1], to_c[i]} - {from_c[i][CoordW-1], from_c[i]};
      s0_d.flags.neg[i]  = diff[CoordW];
      s0_d.ad[i]         = diff[CoordW] ? AbsW'(-diff) : diff[AbsW-1:0];
    end
  end

  // Stage 1: squares. Stage 2: sum of squares.
  logic [2:0][SqW-1:0] sq_q;
  sdr_side_t           s1_q;
  logic                s1_v_q;
  logic [SumW-1:0]     sum_q;
  sdr_side_t           s2_q;
  logic                s2_v_q;
  sdr_side_t           s1_d;

  always_comb begin
    s1_d            = s0_q;
    s1_d.flags.zero = (s0_q.ad == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= s0_q.ad[i] * s0_q.ad[i];
      end
      s1_q  <= s1_d;
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      s2_q  <= s1_q;
    end
  end

  // Magnitude by a pipelined integer square root.
  logic             sq_v;
  logic [RootW-1:0] mag;
  sdr_side_t        sq_side;

  sdr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_v_q),
    .sum_i   (sum_q),
    .side_i  (s2_q),
    .valid_o (sq_v),
    .root_o  (mag),
    .side_o  (sq_side)
  );

  // Products with the length, then the rounding term of half the magnitude.
  logic [2:0][ProdW-1:0] prod_q;
  logic [RootW-1:0]      pm_mag_q;
  sdr_flags_t            pm_flags_q;
  logic                  pm_v_q;
  logic [2:0][NumW-1:0]  num_q;
  logic [RootW-1:0]      nm_mag_q;
  sdr_flags_t            nm_flags_q;
  logic                  nm_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_v_q <= 1'b0;
      nm_v_q <= 1'b0;
    end else if (adv) begin
      pm_v_q <= sq_v;
      nm_v_q <= pm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= sq_side.ad[i] * sq_side.len;
        num_q[i]  <= NumW'(prod_q[i]) + NumW'(pm_mag_q >> 1);
      end
      pm_mag_q   <= mag;
      pm_flags_q <= sq_side.flags;
      nm_mag_q   <= pm_mag_q;
      nm_flags_q <= pm_flags_q;
    end
  end

  // Division by the magnitude.
  logic                 dv_v;
  logic [2:0][QuoW-1:0] quo;
  sdr_flags_t           dv_flags;

  sdr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (nm_v_q),
    .num_i   (num_q),
    .mag_i   (nm_mag_q),
    .flags_i (nm_flags_q),
    .valid_o (dv_v),
    .quo_o   (quo),
    .flags_o (dv_flags)
  );

  // Output register: restore signs; coinciding points give zero.
  logic [2:0][OutW-1:0] res_d;
  logic [2:0][OutW-1:0] res_q;
  logic                 zero_q;

  always_comb begin
    logic [OutW-1:0] mag_c;
    for (int i = 0; i < 3; i++) begin
      mag_c    = {1'b0, quo[i]};
      res_d[i] = dv_flags.zero ? '0 : (dv_flags.neg[i] ? OutW'(-mag_c) : mag_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      zero_q <= dv_flags.zero;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = res_q[0];
  assign out_y_o      = res_q[1];
  assign out_z_o      = res_q[2];
  assign zero_error_o = zero_q;

endmodule

@@ tb/segment_rescale_checker.sv @@
// ----------------------------------------------------------------------------
// segment_rescale_checker: predicts and checks rescaled segment vectors
// Watches both channels, computes the expected vector for every accepted
// item and compares each accepted result against the oldest expectation.
// ----------------------------------------------------------------------------
module segment_rescale_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] from_x_i,
  input  logic signed [31:0] from_y_i,
  input  logic signed [31:0] from_z_i,
  input  logic signed [31:0] to_x_i,
  input  logic signed [31:0] to_y_i,
  input  logic signed [31:0] to_z_i,
  input  logic [30:0]        target_length_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  input  logic               zero_error_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        zero_err;
  } rescaled_vec_t;

  rescaled_vec_t pending_vecs[$];

  assign pending_o = pending_vecs.size();

  // Floor of the square root of a sum of squares, bit by bit.
  function automatic logic [32:0] magnitude_floor(logic [65:0] sum_sq);
    logic [32:0] root;
    logic [32:0] trial;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (33'd1 << b);
      if ({33'd0, trial} * {33'd0, trial} <= sum_sq) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] scaled_component(logic signed [32:0] diff,
                                                   logic [30:0] len,
                                                   logic [32:0] mag);
    logic [32:0]  mag_abs;
    logic [127:0] quo;
    mag_abs = diff[32] ? -diff : diff;
    quo = ({95'd0, mag_abs} * len + (mag >> 1)) / mag;
    return diff[32] ? -quo[31:0] : quo[31:0];
  endfunction

  function automatic rescaled_vec_t rescale_segment(logic signed [32:0] dx,
                                                    logic signed [32:0] dy,
                                                    logic signed [32:0] dz,
                                                    logic [30:0] len);
    rescaled_vec_t    v;
    logic [65:0]      sum_sq;
    logic [32:0]      mag;
    logic signed [65:0] sx, sy, sz;
    sx = dx;
    sy = dy;
    sz = dz;
    sum_sq = sx * sx + sy * sy + sz * sz;
    v = '0;
    if (sum_sq == 0) begin
      v.zero_err = 1'b1;
      return v;
    end
    mag = magnitude_floor(sum_sq);
    v.x = scaled_component(dx, len, mag);
    v.y = scaled_component(dy, len, mag);
    v.z = scaled_component(dz, len, mag);
    return v;
  endfunction

  always @(posedge clk_i) begin
    rescaled_vec_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        pending_vecs.push_back(rescale_segment(
          $signed({to_x_i[31], to_x_i}) - $signed({from_x_i[31], from_x_i}),
          $signed({to_y_i[31], to_y_i}) - $signed({from_y_i[31], from_y_i}),
          $signed({to_z_i[31], to_z_i}) - $signed({from_z_i[31], from_z_i}),
          target_length_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_vecs.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h err=%b", $time,
                   out_x_i, out_y_i, out_z_i, zero_error_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_vecs.pop_front();
          if (want.x !== out_x_i || want.y !== out_y_i || want.z !== out_z_i ||
              want.zero_err !== zero_error_i) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h err=%b", $time,
                     want.x, want.y, want.z, want.zero_err);
            $display("%0t:          actual   x=%h y=%h z=%h err=%b", $time,
                     out_x_i, out_y_i, out_z_i, zero_error_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the segment direction rescale block
// Drives directed and random point pairs with varied idling on both sides,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;

  // Wait after the last expected result before the verdict, with a good margin.
  localparam int DrainCycles = 200;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] from_x, from_y, from_z;
  logic signed [31:0] to_x, to_y, to_z;
  logic [30:0]        target_length;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_x, out_y, out_z;
  logic               zero_error;
  int                 fail_count;
  int                 pending;

  // Idle percentages for the sender and the receiver; changed per phase.
  int send_idle_pct;
  int recv_idle_pct;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  segment_direction_rescale dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .from_x_i        (from_x),
    .from_y_i        (from_y),
    .from_z_i        (from_z),
    .to_x_i          (to_x),
    .to_y_i          (to_y),
    .to_z_i          (to_z),
    .target_length_i (target_length),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_x_o         (out_x),
    .out_y_o         (out_y),
    .out_z_o         (out_z),
    .zero_error_o    (zero_error)
  );

  segment_rescale_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .from_x_i        (from_x),
    .from_y_i        (from_y),
    .from_z_i        (from_z),
    .to_x_i          (to_x),
    .to_y_i          (to_y),
    .to_z_i          (to_z),
    .target_length_i (target_length),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_x_i         (out_x),
    .out_y_i         (out_y),
    .out_z_i         (out_z),
    .zero_error_i    (zero_error),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // The receiver decides its ready at each falling edge, independent of
  // whether a result is waiting, so stalls land on every pipeline phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one item and holds it until the block takes it. Idle cycles are
  // inserted before raising valid, never while valid is up.
  task automatic send_segment(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                              logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                              logic [30:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    from_x        <= fx;
    from_y        <= fy;
    from_z        <= fz;
    to_x          <= tx;
    to_y          <= ty;
    to_z          <= tz;
    target_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // A random coordinate: mostly full range, sometimes near a small base so
  // that short segments and huge ones both show up often.
  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom_range(15) - 8;
      1: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] random_length();
    case ($urandom_range(4))
      0: return 31'($urandom_range(3));
      1: return 31'h7fffffff - 31'($urandom_range(3));
      2: return 31'($urandom_range(32'h0002_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [31:0] fx, fy, fz;
    for (int n = 0; n < count; n++) begin
      fx = random_coord();
      fy = random_coord();
      fz = random_coord();
      // About one item in twelve repeats the start point, giving zero_error,
      // and some others move along one axis only.
      case ($urandom_range(11))
        0: send_segment(fx, fy, fz, fx, fy, fz, random_length());
        1: send_segment(fx, fy, fz, fx + random_coord(), fy, fz, random_length());
        default: send_segment(fx, fy, fz, fx + random_coord(), fy + random_coord(),
                              fz + random_coord(), random_length());
      endcase
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    from_x        = '0;
    from_y        = '0;
    from_z        = '0;
    to_x          = '0;
    to_y          = '0;
    to_z          = '0;
    target_length = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: coinciding points, zero length, the extremes of every
    // coordinate and of the length, and differences that need all 33 bits.
    send_segment(0, 0, 0, 0, 0, 0, 31'h7fffffff);
    send_segment(32'h7fffffff, 32'h80000000, 5, 32'h7fffffff, 32'h80000000, 5,
                 31'h10000);
    send_segment(0, 0, 0, 32'h10000, 0, 0, 0);
    send_segment(0, 0, 0, 32'h10000, 0, 0, 31'h7fffffff);
    send_segment(0, 0, 0, 0, 32'hffff0000, 0, 31'h30000);
    send_segment(0, 0, 0, 0, 0, 1, 1);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
    send_segment(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 31'h7fffffff);
    send_segment(0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 1);
    send_segment(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 31'h7fffffff);
    send_segment(0, 0, 0, 3, 4, 0, 31'h50000);
    send_segment(0, 0, 0, 1, 1, 0, 1);
    send_segment(0, 0, 0, 1, 1, 1, 31'h7fffffff);
    send_segment(32'h55555555, 32'haaaaaaaa, 32'h12345678,
                 32'haaaaaaaa, 32'h55555555, 32'hedcba987, 31'h2aaaaaaa);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 31'h55555555);

    // Let everything drain once before random traffic starts.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 60;
    send_random(650);
    send_idle_pct = 60;
    recv_idle_pct = 16;
    send_random(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(650);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Worst case is roughly 2000 items with long sender gaps and 60% receiver
  // stalls; the timeout leaves a wide margin.
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sdr_pkg.sv
rtl/core/sdr_sqrt.sv
rtl/core/sdr_div.sv
rtl/core/segment_direction_rescale.sv
tb/segment_rescale_checker.sv
tb/tb.sv
